[rtl/core/cubic_bezier_easing_eval_defines.svh]
// Assertion macros shared by the easing evaluator RTL.
// Checks are compiled only in simulation; synthesis sees empty bodies.
// Depends on nothing; users provide clk and arst_n in scope.
`ifndef CUBIC_BEZIER_EASING_EVAL_DEFINES_SVH
`define CUBIC_BEZIER_EASING_EVAL_DEFINES_SVH

`ifndef SYNTHESIS

// check gated by reset
`define CBE_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("cbe assertion failed");

// check that also holds while reset is applied
`define CBE_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) (expr)) \
		else $error("cbe assertion failed");

`else

`define CBE_ASSERT(lbl, expr)
`define CBE_ASSERT_ALWAYS(lbl, expr)

`endif

`endif

[rtl/core/cbe_pkg.sv]
// Shared widths, constants, micro-op codes and structs of the easing evaluator.
// Used by cbe_mul, cbe_div and cubic_bezier_easing_eval; depends on nothing.
package cbe_pkg;

	// curve parameter t is Q0.24, held in 25 bits so that one fits
	localparam int T_BITS = 24;
	localparam int T_W    = T_BITS + 1;
	// multiplier operands and product
	localparam int B_W    = 28;
	localparam int P_W    = 54;
	// accumulated axis values, residual and slope
	localparam int ACC_W  = 44;
	// divider: magnitude of residual shifted by t bits over slope magnitude
	localparam int DVD_W  = ACC_W + T_BITS;
	localparam int DVS_W  = ACC_W;

	// port field widths
	localparam int PRG_W  = 19;
	localparam int EAS_W  = 20;
	localparam int CX_W   = 17;
	localparam int CY_W   = 20;

	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_BITS;

	// tolerances in t lsbs
	localparam logic [ACC_W-1:0] TOL_FINE   = ACC_W'(17);
	localparam logic [ACC_W-1:0] TOL_COARSE = ACC_W'(1678);

	// output saturation bounds
	localparam logic signed [ACC_W:0] OUT_MAX = (ACC_W+1)'(524287);
	localparam logic signed [ACC_W:0] OUT_MIN = -(ACC_W+1)'(524288);

	// micro-op codes of the shared multiplier program
	typedef logic [3:0] op_t;
	localparam op_t OP_UU  = 4'd0;
	localparam op_t OP_UT  = 4'd1;
	localparam op_t OP_TT  = 4'd2;
	localparam op_t OP_UUT = 4'd3;
	localparam op_t OP_UTT = 4'd4;
	localparam op_t OP_TTT = 4'd5;
	localparam op_t OP_VK1 = 4'd6;
	localparam op_t OP_VK2 = 4'd7;
	localparam op_t OP_SK1 = 4'd8;
	localparam op_t OP_SK4 = 4'd9;
	localparam op_t OP_SK5 = 4'd10;

	// request into the shared multiplier
	typedef struct packed {
		logic                  valid;
		logic [T_W-1:0]        a;
		logic signed [B_W-1:0] b;
		logic                  shift_f;
	} mul_req_t;

	// rounded product out of the shared multiplier
	typedef struct packed {
		logic                    valid;
		logic signed [ACC_W-1:0] val;
	} mul_res_t;

	function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] v);
		abs_acc = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
	endfunction

endpackage

[rtl/core/cbe_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Serves the newton step of the easing evaluator; depends on cbe_pkg.
module cbe_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cbe_pkg::DVD_W-1:0]  dividend,
	input  logic [cbe_pkg::DVS_W-1:0]  divisor,
	output logic                       done,
	output logic [cbe_pkg::DVD_W-1:0]  quotient
);
	import cbe_pkg::*;

	localparam int CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W+1:0] diff;
	logic             fits;

	// trial subtract of the shifted remainder
	always_comb begin
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
		fits   = !diff[DVS_W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

[rtl/core/cbe_mul.sv]
// Shared two-stage multiplier with round-half-away shift by 24 or by FRAC_BITS.
// Every product of the curve evaluation goes through it; depends on cbe_pkg.
module cbe_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cbe_pkg::mul_req_t req,
	output cbe_pkg::mul_res_t res
);
	import cbe_pkg::*;

	localparam logic [P_W-1:0] HALF_F = P_W'(1) << (FRAC_BITS - 1);
	localparam logic [P_W-1:0] HALF_T = P_W'(1) << (T_BITS - 1);

	logic                  valid_s1;
	logic                  shf_s1;
	logic signed [P_W-1:0] prod_s1;
	logic                  valid_s2;
	logic signed [ACC_W-1:0] val_s2;
	logic signed [P_W-1:0] prod;
	logic [P_W-1:0]        mag;
	logic [P_W-1:0]        rmag;
	logic signed [P_W-1:0] rsgn;

	// stage 1: product
	assign prod = $signed({1'b0, req.a}) * req.b;

	// stage 2: rounded shift on the magnitude, sign restored
	always_comb begin
		mag  = prod_s1[P_W-1] ? P_W'(-prod_s1) : P_W'(prod_s1);
		rmag = shf_s1 ? ((mag + HALF_F) >> FRAC_BITS) : ((mag + HALF_T) >> T_BITS);
		rsgn = prod_s1[P_W-1] ? -$signed(rmag) : $signed(rmag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		shf_s1  <= req.shift_f;
		val_s2  <= rsgn[ACC_W-1:0];
	end

	assign res.valid = valid_s2;
	assign res.val   = val_s2;

endmodule

[rtl/core/cubic_bezier_easing_eval.sv]
// Top level of the cubic bezier easing evaluator: apb registers and sequencer.
// Uses cbe_pkg, cbe_mul, cbe_div and cubic_bezier_easing_eval_defines.svh.
//
//   channel   signals                              item
//   input     in_valid, in_ready, progress         one progress value, Q(FRAC_BITS)
//   output    out_valid, out_ready, eased          one curve value, Q(FRAC_BITS)
//   config    psel penable pwrite paddr pwdata     control points x1 y1 x2 y2
//
// Progress at or below zero or at or above one goes straight to the done state and raises out_valid.
// Otherwise all multiplies go one at a time through the one shared multiplier: a curve value
// is 8 multiplies, a slope 3 more, and each full newton step ends in a divide.
// Each item runs up to NEWTON_STEPS newton steps, which can stop early, and then
// BISECT_STEPS bisection steps when the newton result is still too far off.
// in_ready is high only while idle; a held output item stalls the done state.
// Reset restores the control points and clears out_valid; a finished item waits in the output register.
`include "cubic_bezier_easing_eval_defines.svh"
module cubic_bezier_easing_eval #(
	parameter int NEWTON_STEPS = 8,
	parameter int BISECT_STEPS = 24,
	parameter int FRAC_BITS    = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [3:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [cbe_pkg::PRG_W-1:0]  progress,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [cbe_pkg::EAS_W-1:0]  eased
);
	import cbe_pkg::*;

	localparam int NW = $clog2(NEWTON_STEPS + 1);
	localparam int BW = $clog2(BISECT_STEPS + 1);
	localparam int YS = T_BITS - FRAC_BITS;
	localparam logic [ACC_W-1:0] Y_HALF = ACC_W'((longint'(1) << YS) >> 1);
	localparam logic signed [31:0] F_ONE_32 = 32'(longint'(1) << FRAC_BITS);
	localparam logic signed [B_W-1:0] F_ONE_B = B_W'(longint'(1) << FRAC_BITS);
	localparam longint ONE_L = longint'(1) << FRAC_BITS;
	localparam logic [EAS_W-1:0] ONE_SAT = EAS_W'((ONE_L > 524287) ? 524287 : ONE_L);

	// register indexes
	localparam logic [1:0] REG_X1 = 2'd0;
	localparam logic [1:0] REG_Y1 = 2'd1;
	localparam logic [1:0] REG_X2 = 2'd2;
	localparam logic [1:0] REG_Y2 = 2'd3;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_NVAL   = 3'd1;
	localparam logic [2:0] S_NSLOPE = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_CHK    = 3'd4;
	localparam logic [2:0] S_BIS    = 3'd5;
	localparam logic [2:0] S_YVAL   = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [CX_W-1:0]        x1_q, x2_q;
	logic signed [CY_W-1:0] y1_q, y2_q;

	logic [2:0]             state_q;
	op_t                    op_q;
	logic                   busy_q;
	logic [T_W-1:0]         t_q, xt_q, lo_q, hi_q;
	logic [T_W-1:0]         uu_q, ut_q, tt_q, uut_q, utt_q;
	logic signed [ACC_W-1:0] acc_q, err_q;
	logic [NW-1:0]          nit_q;
	logic [BW-1:0]          bit_q;
	logic                   qneg_q;
	logic [EAS_W-1:0]       pend_q;
	logic [EAS_W-1:0]       eased_q;
	logic                   out_valid_q;
	logic signed [B_W-1:0]  kx1_q, kx2_q, ky1_q, ky2_q, k4_q, k5_q;

	mul_req_t               mul_req;
	mul_res_t               mul_res;
	logic                   div_start;
	logic                   div_done;
	logic [DVD_W-1:0]       div_quot;
	logic [DVD_W-1:0]       div_dvd;
	logic [DVS_W-1:0]       div_dvs;

	logic                   wr;
	logic                   accept;
	logic                   in_eval;
	logic                   last_op;
	logic [T_W-1:0]         u;
	logic signed [ACC_W-1:0] acc_nxt, err_nxt;
	logic signed [B_W-1:0]  x1_b, x2_b, y1_b, y2_b, dx_b, rx_b;
	logic signed [DVD_W+1:0] t_x, q_x, t_n;
	logic [T_W-1:0]         t_clamp;
	logic [T_W-1:0]         lo_n, hi_n;
	logic [T_W:0]           mid_sum;
	logic [ACC_W-1:0]       y_mag, y_r;
	logic signed [ACC_W:0]  y_s;
	logic [EAS_W-1:0]       y_sat;

	// apb register file
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= CX_W'(16384);
			y1_q <= CY_W'(6554);
			x2_q <= CX_W'(16384);
			y2_q <= CY_W'(65536);
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_X1: x1_q <= pwdata[CX_W-1:0];
				REG_Y1: y1_q <= $signed(pwdata[CY_W-1:0]);
				REG_X2: x2_q <= pwdata[CX_W-1:0];
				REG_Y2: y2_q <= $signed(pwdata[CY_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_X1: prdata = 32'(x1_q);
			REG_Y1: prdata = 32'(y1_q);
			REG_X2: prdata = 32'(x2_q);
			REG_Y2: prdata = 32'(y2_q);
			default: prdata = '0;
		endcase
	end

	// control point operands; the coefficients built from them are latched per item on accept
	always_comb begin
		x1_b = B_W'(x1_q);
		x2_b = B_W'(x2_q);
		y1_b = B_W'(y1_q);
		y2_b = B_W'(y2_q);
		dx_b = x2_b - x1_b;
		rx_b = F_ONE_B - x2_b;
	end

	// handshake
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign eased     = $signed(eased_q);

	// operand select for the multiplier program
	assign u       = T_ONE - t_q;
	assign in_eval = (state_q == S_NVAL) || (state_q == S_NSLOPE) || (state_q == S_CHK)
		|| (state_q == S_BIS) || (state_q == S_YVAL);

	always_comb begin
		mul_req.valid = in_eval && !busy_q;
		unique case (op_q)
			OP_UU: begin
				mul_req.a = u;     mul_req.b = $signed(B_W'(u));   mul_req.shift_f = 1'b0;
			end
			OP_UT: begin
				mul_req.a = u;     mul_req.b = $signed(B_W'(t_q)); mul_req.shift_f = 1'b0;
			end
			OP_TT: begin
				mul_req.a = t_q;   mul_req.b = $signed(B_W'(t_q)); mul_req.shift_f = 1'b0;
			end
			OP_UUT: begin
				mul_req.a = uu_q;  mul_req.b = $signed(B_W'(t_q)); mul_req.shift_f = 1'b0;
			end
			OP_UTT: begin
				mul_req.a = ut_q;  mul_req.b = $signed(B_W'(t_q)); mul_req.shift_f = 1'b0;
			end
			OP_TTT: begin
				mul_req.a = tt_q;  mul_req.b = $signed(B_W'(t_q)); mul_req.shift_f = 1'b0;
			end
			OP_VK1: begin
				mul_req.a = uut_q; mul_req.shift_f = 1'b1;
				mul_req.b = (state_q == S_YVAL) ? ky1_q : kx1_q;
			end
			OP_VK2: begin
				mul_req.a = utt_q; mul_req.shift_f = 1'b1;
				mul_req.b = (state_q == S_YVAL) ? ky2_q : kx2_q;
			end
			OP_SK1: begin
				mul_req.a = uu_q;  mul_req.b = kx1_q; mul_req.shift_f = 1'b1;
			end
			OP_SK4: begin
				mul_req.a = ut_q;  mul_req.b = k4_q;  mul_req.shift_f = 1'b1;
			end
			OP_SK5: begin
				mul_req.a = tt_q;  mul_req.b = k5_q;  mul_req.shift_f = 1'b1;
			end
			default: begin
				mul_req.a = '0;    mul_req.b = '0;    mul_req.shift_f = 1'b0;
			end
		endcase
	end

	cbe_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.res    (mul_res)
	);

	// accumulate, residual and end of program
	always_comb begin
		acc_nxt = ((op_q == OP_TTT) || (op_q == OP_SK1)) ? mul_res.val : acc_q + mul_res.val;
		err_nxt = acc_nxt - $signed(ACC_W'(xt_q));
		last_op = (state_q == S_NSLOPE) ? (op_q == OP_SK5) : (op_q == OP_VK2);
	end

	// newton divide request
	assign div_start = (state_q == S_NSLOPE) && mul_res.valid && last_op
		&& (abs_acc(acc_nxt) >= TOL_FINE);
	assign div_dvd   = DVD_W'(abs_acc(err_q)) << T_BITS;
	assign div_dvs   = abs_acc(acc_nxt);

	cbe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quot)
	);

	// newton update with clamp to [0, one]
	always_comb begin
		t_x = $signed((DVD_W+2)'(t_q));
		q_x = $signed((DVD_W+2)'(div_quot));
		t_n = qneg_q ? t_x + q_x : t_x - q_x;
		if (t_n < 0)
			t_clamp = '0;
		else if (t_n > $signed((DVD_W+2)'(T_ONE)))
			t_clamp = T_ONE;
		else
			t_clamp = t_n[T_W-1:0];
	end

	// bisection bracket update
	always_comb begin
		lo_n    = (acc_nxt < $signed(ACC_W'(xt_q))) ? t_q : lo_q;
		hi_n    = (acc_nxt < $signed(ACC_W'(xt_q))) ? hi_q : t_q;
		mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
	end

	// final y: round to output format and saturate
	always_comb begin
		y_mag = abs_acc(acc_nxt);
		y_r   = (y_mag + Y_HALF) >> YS;
		y_s   = acc_nxt[ACC_W-1] ? -$signed({1'b0, y_r}) : $signed({1'b0, y_r});
		if (y_s > OUT_MAX)
			y_sat = OUT_MAX[EAS_W-1:0];
		else if (y_s < OUT_MIN)
			y_sat = OUT_MIN[EAS_W-1:0];
		else
			y_sat = y_s[EAS_W-1:0];
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_UU;
			busy_q      <= 1'b0;
			nit_q       <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			if (mul_req.valid)
				busy_q <= 1'b1;
			if (mul_res.valid)
				busy_q <= 1'b0;
			if (mul_res.valid && !last_op)
				op_q <= op_q + 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						nit_q <= '0;
						op_q  <= OP_UU;
						if (progress <= 0 || 32'(progress) >= F_ONE_32)
							state_q <= S_DONE;
						else
							state_q <= S_NVAL;
					end
				end
				S_NVAL: begin
					if (mul_res.valid && last_op) begin
						if (abs_acc(err_nxt) < TOL_FINE) begin
							state_q <= S_CHK;
							op_q    <= OP_UU;
						end else begin
							state_q <= S_NSLOPE;
							op_q    <= OP_SK1;
						end
					end
				end
				S_NSLOPE: begin
					if (mul_res.valid && last_op) begin
						if (div_start) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_CHK;
							op_q    <= OP_UU;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						op_q  <= OP_UU;
						nit_q <= nit_q + 1'b1;
						if (nit_q == NW'(NEWTON_STEPS - 1))
							state_q <= S_CHK;
						else
							state_q <= S_NVAL;
					end
				end
				S_CHK: begin
					if (mul_res.valid && last_op) begin
						op_q  <= OP_UU;
						bit_q <= '0;
						if (abs_acc(err_nxt) > TOL_COARSE)
							state_q <= S_BIS;
						else
							state_q <= S_YVAL;
					end
				end
				S_BIS: begin
					if (mul_res.valid && last_op) begin
						op_q  <= OP_UU;
						bit_q <= bit_q + 1'b1;
						if (bit_q == BW'(BISECT_STEPS - 1))
							state_q <= S_YVAL;
					end
				end
				S_YVAL: begin
					if (mul_res.valid && last_op)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			xt_q   <= T_W'(progress[PRG_W-2:0]) << YS;
			t_q    <= T_W'(progress[PRG_W-2:0]) << YS;
			kx1_q  <= (x1_b <<< 1) + x1_b;
			kx2_q  <= (x2_b <<< 1) + x2_b;
			ky1_q  <= (y1_b <<< 1) + y1_b;
			ky2_q  <= (y2_b <<< 1) + y2_b;
			k4_q   <= (dx_b <<< 2) + (dx_b <<< 1);
			k5_q   <= (rx_b <<< 1) + rx_b;
			pend_q <= (progress <= 0) ? '0 : ONE_SAT;
		end
		if (mul_res.valid) begin
			acc_q <= acc_nxt;
			unique case (op_q)
				OP_UU:  uu_q  <= mul_res.val[T_W-1:0];
				OP_UT:  ut_q  <= mul_res.val[T_W-1:0];
				OP_UTT: utt_q <= mul_res.val[T_W-1:0];
				OP_TT:  tt_q  <= mul_res.val[T_W-1:0];
				OP_UUT: uut_q <= mul_res.val[T_W-1:0];
				default: ;
			endcase
		end
		if (state_q == S_NVAL && mul_res.valid && last_op)
			err_q <= err_nxt;
		if (div_start)
			qneg_q <= err_q[ACC_W-1] ^ acc_nxt[ACC_W-1];
		if (state_q == S_DIV && div_done)
			t_q <= t_clamp;
		if (state_q == S_CHK && mul_res.valid && last_op) begin
			lo_q <= '0;
			hi_q <= T_ONE;
			if (abs_acc(err_nxt) > TOL_COARSE)
				t_q <= T_ONE >> 1;
		end
		if (state_q == S_BIS && mul_res.valid && last_op) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
			if (bit_q != BW'(BISECT_STEPS - 1))
				t_q <= mid_sum[T_W:1];
		end
		if (state_q == S_YVAL && mul_res.valid && last_op)
			pend_q <= y_sat;
		if (state_q == S_DONE && (!out_valid_q || out_ready))
			eased_q <= pend_q;
	end

	// checks
	`CBE_ASSERT(a_t_in_range, (state_q == S_IDLE) || (state_q == S_DONE) || (t_q <= T_ONE))
	`CBE_ASSERT(a_bis_bracket, (state_q == S_BIS) |-> (lo_q <= t_q && t_q <= hi_q))
	`CBE_ASSERT(a_mul_res_issued, mul_res.valid |-> busy_q)
	`CBE_ASSERT(a_accept_leaves_idle, accept |=> (state_q != S_IDLE))
	`CBE_ASSERT(a_div_done_in_div, div_done |-> (state_q == S_DIV))

endmodule

[bench/cubic_bezier_easing_eval_test.sv]
// Self-checking bench for cubic_bezier_easing_eval: apb control point setup,
// random progress items with stalls, and a bit-exact curve predictor.
// Depends on cbe_pkg and the cubic_bezier_easing_eval rtl.
module cubic_bezier_easing_eval_test;
	import cbe_pkg::*;

	localparam int       FRAC     = 16;
	localparam int       TB       = 24;
	localparam longint   T_UNIT   = 64'sd1 << TB;
	localparam longint   F_UNIT   = 64'sd1 << FRAC;
	localparam int       N_STEPS  = 8;
	localparam int       B_STEPS  = 24;
	localparam longint   FINE     = 17;
	localparam longint   COARSE   = 1678;
	// register byte addresses
	localparam logic [3:0] ADDR_X1 = 4'd0;
	localparam logic [3:0] ADDR_Y1 = 4'd4;
	localparam logic [3:0] ADDR_X2 = 4'd8;
	localparam logic [3:0] ADDR_Y2 = 4'd12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [PRG_W-1:0] progress = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [EAS_W-1:0] eased;

	// control point copies used by the predictor
	longint pt_x1 = 16384, pt_y1 = 6554, pt_x2 = 16384, pt_y2 = 65536;

	logic signed [PRG_W-1:0] pending_progress[$];
	logic signed [EAS_W-1:0] expected_eased[$];
	int errors = 0;
	bit quiet = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	cubic_bezier_easing_eval u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .progress(progress),
		.out_valid(out_valid), .out_ready(out_ready), .eased(eased)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// divide by a power of two, rounding ties away from zero
	function automatic longint rnd_shift(longint v, int s);
		longint half;
		if (s == 0) return v;
		half = 64'sd1 <<< (s - 1);
		if (v >= 0) return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic longint curve_coord(longint p1, longint p2, longint t);
		longint u, uu, ut, tt;
		u  = T_UNIT - t;
		uu = rnd_shift(u * u, TB);
		ut = rnd_shift(u * t, TB);
		tt = rnd_shift(t * t, TB);
		return rnd_shift(3 * rnd_shift(uu * t, TB) * p1, FRAC)
			+ rnd_shift(3 * rnd_shift(ut * t, TB) * p2, FRAC) + rnd_shift(tt * t, TB);
	endfunction

	function automatic longint bezier_slope(longint p1, longint p2, longint t);
		longint u, uu, ut, tt;
		u  = T_UNIT - t;
		uu = rnd_shift(u * u, TB);
		ut = rnd_shift(u * t, TB);
		tt = rnd_shift(t * t, TB);
		return rnd_shift(3 * uu * p1, FRAC) + rnd_shift(6 * ut * (p2 - p1), FRAC)
			+ rnd_shift(3 * tt * (F_UNIT - p2), FRAC);
	endfunction

	function automatic longint abs_l(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// solve X(t) = x by newton then bisection, return Y(t)
	function automatic logic signed [EAS_W-1:0] ease_value(logic signed [PRG_W-1:0] x_in);
		longint x, xt, t, err, slope, y, lo, hi;
		x = x_in;
		if (x <= 0) return '0;
		if (x >= F_UNIT) return EAS_W'(F_UNIT);
		xt = x <<< (TB - FRAC);
		t = xt;
		for (int i = 0; i < N_STEPS; i++) begin
			err = curve_coord(pt_x1, pt_x2, t) - xt;
			if (abs_l(err) < FINE) break;
			slope = bezier_slope(pt_x1, pt_x2, t);
			if (abs_l(slope) < FINE) break;
			t = t - (err * T_UNIT) / slope;
			if (t < 0) t = 0;
			if (t > T_UNIT) t = T_UNIT;
		end
		if (abs_l(curve_coord(pt_x1, pt_x2, t) - xt) > COARSE) begin
			lo = 0;
			hi = T_UNIT;
			for (int i = 0; i < B_STEPS; i++) begin
				t = (lo + hi) >>> 1;
				if (curve_coord(pt_x1, pt_x2, t) < xt) lo = t;
				else hi = t;
			end
		end
		y = rnd_shift(curve_coord(pt_y1, pt_y2, t), TB - FRAC);
		if (y > 524287) y = 524287;
		if (y < -524288) y = -524288;
		return EAS_W'(y);
	endfunction

	// input driver: feeds pending items with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_eased.push_back(ease_value(progress));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_progress.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 4) == 0) begin
					send_gap <= $urandom_range(0, 2);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					progress <= pending_progress.pop_front();
				end
			end
		end
	end

	// output monitor: random stall bursts and result check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_eased.size() == 0) begin
					$display("%0t: unexpected eased item %0d", $time, eased);
					errors++;
				end else begin
					logic signed [EAS_W-1:0] want;
					want = expected_eased.pop_front();
					if (want !== eased) begin
						$display("%0t: eased mismatch expected %0d actual %0d",
							$time, want, eased);
						errors++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				recv_gap <= $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic apb_write(logic [3:0] addr, longint value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			ADDR_X1: pt_x1 = value & 64'h1FFFF;
			ADDR_Y1: pt_y1 = longint'($signed(value[19:0]));
			ADDR_X2: pt_x2 = value & 64'h1FFFF;
			ADDR_Y2: pt_y2 = longint'($signed(value[19:0]));
			default: ;
		endcase
	endtask

	task automatic set_curve(longint x1, longint y1, longint x2, longint y2);
		apb_write(ADDR_X1, x1);
		apb_write(ADDR_Y1, y1);
		apb_write(ADDR_X2, x2);
		apb_write(ADDR_Y2, y2);
	endtask

	task automatic drain();
		wait (pending_progress.size() == 0 && !in_valid && expected_eased.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	// mostly inside (0,1), some across the whole field
	task automatic queue_random(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0)
				pending_progress.push_back(PRG_W'($urandom));
			else if ($urandom_range(0, 5) == 0)
				pending_progress.push_back(PRG_W'($urandom_range(0, 262144) - 131072));
			else
				pending_progress.push_back(PRG_W'($urandom_range(1, 65535)));
		end
	endtask

	initial begin
		longint directed[];
		directed = '{0, -131072, -1, 1, 2, 100, 16384, 32768, 49152,
			65534, 65535, 65536, 65537, 131071, 131072, -262144, 262143};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset curve, directed edges
		foreach (directed[i]) pending_progress.push_back(PRG_W'(directed[i]));
		queue_random(150);
		drain();

		set_curve(0, 0, 65536, 65536);
		foreach (directed[i]) pending_progress.push_back(PRG_W'(directed[i]));
		queue_random(200);
		drain();

		set_curve(65536, -262144, 0, 262144);
		queue_random(200);
		drain();

		set_curve(65536, 262144, 65536, -262144);
		queue_random(200);
		drain();

		set_curve(0, 262144, 0, -262144);
		queue_random(200);
		drain();

		// control x above one
		set_curve(131071, 131072, 100000, -65536);
		queue_random(150);
		drain();

		set_curve(0, 0, 0, 0);
		queue_random(100);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			set_curve($urandom_range(0, 65536), $urandom_range(0, 524288) - 262144,
				$urandom_range(0, 65536), $urandom_range(0, 524288) - 262144);
			queue_random(150);
			drain();
		end

		// closing stretch without idling
		quiet = 1'b1;
		set_curve($urandom_range(0, 65536), $urandom_range(0, 524288) - 262144,
			$urandom_range(0, 65536), $urandom_range(0, 524288) - 262144);
		queue_random(150);
		drain();
		repeat (40) @(posedge clk);

		if (errors == 0)
			$display("PASS cubic_bezier_easing_eval");
		else
			$display("FAIL cubic_bezier_easing_eval");
		$finish;
	end

	// run limit
	initial begin
		#400000000;
		$display("FAIL cubic_bezier_easing_eval");
		$finish;
	end

endmodule
